FILE: rtl/assert_macros.svh
// assertion macros for the rtl files, included only by smx_ctrl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);
`define ASSERT_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, cond, msg)
`define ASSERT_IMPLY(lbl, ante, cons, msg)
`define ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

FILE: rtl/smx_pkg.sv
// shared types, operation and fault codes for the stack machine executor
package smx_pkg;
	localparam int VALUE_STACK_DEPTH_DEF  = 64;
	localparam int RETURN_STACK_DEPTH_DEF = 16;
	localparam int PROGRAM_LENGTH_DEF     = 1024;

	localparam logic [4:0] OP_PUSH    = 5'd0;
	localparam logic [4:0] OP_PUSHREG = 5'd1;
	localparam logic [4:0] OP_POPREG  = 5'd2;
	localparam logic [4:0] OP_JA      = 5'd3;
	localparam logic [4:0] OP_JAE     = 5'd4;
	localparam logic [4:0] OP_JB      = 5'd5;
	localparam logic [4:0] OP_JBE     = 5'd6;
	localparam logic [4:0] OP_JE      = 5'd7;
	localparam logic [4:0] OP_JNE     = 5'd8;
	localparam logic [4:0] OP_JMP     = 5'd9;
	localparam logic [4:0] OP_CALL    = 5'd10;
	localparam logic [4:0] OP_RET     = 5'd11;
	localparam logic [4:0] OP_ADD     = 5'd12;
	localparam logic [4:0] OP_SUB     = 5'd13;
	localparam logic [4:0] OP_MUL     = 5'd14;
	localparam logic [4:0] OP_DIV     = 5'd15;
	localparam logic [4:0] OP_DUP     = 5'd16;
	localparam logic [4:0] OP_IN      = 5'd17;
	localparam logic [4:0] OP_OUT     = 5'd18;
	localparam logic [4:0] OP_END     = 5'd19;

	localparam logic [2:0] FLT_NONE   = 3'd0;
	localparam logic [2:0] FLT_UNDER  = 3'd1;
	localparam logic [2:0] FLT_OVER   = 3'd2;
	localparam logic [2:0] FLT_BADREG = 3'd3;
	localparam logic [2:0] FLT_CALL   = 3'd4;
	localparam logic [2:0] FLT_DIVZ   = 3'd5;
	localparam logic [2:0] FLT_TARGET = 3'd6;

	localparam int DIV_STEPS = 48;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_DIV,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic accept;
		logic start_div;
		logic commit;
	} cmd_t;

	typedef struct packed {
		logic div_go;
		logic div_done;
	} stat_t;
endpackage

FILE: rtl/stack_machine_executor_unit.sv
// top level of the stack machine executor
//
// input channel: op, operand, in_value with in_valid / in_stall; a transaction
// is one instruction. result channel: next_index, out_valid, out_value,
// halted, fault with res_valid / res_stall; exactly one result transaction
// per instruction, in order.
//
// after acceptance most operations execute (stack operands and product
// register) and then commit; a divide runs the one-bit-per-cycle restoring
// divider between execute and commit. a new instruction is taken only after
// the current one has committed.
//
// reset (arst_n low) empties both stacks, clears the general registers,
// the program index and the halt flag; no clearing pass is needed.
// the result sits in an output register; a stalled result holds while the
// next instruction is already executing, and commit waits only if that
// register is still occupied.
// once halted, every instruction is ignored and the index is repeated.
module stack_machine_executor_unit import smx_pkg::*; #(
	parameter int VALUE_STACK_DEPTH  = VALUE_STACK_DEPTH_DEF,
	parameter int RETURN_STACK_DEPTH = RETURN_STACK_DEPTH_DEF,
	parameter int PROGRAM_LENGTH     = PROGRAM_LENGTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [4:0]         op,
	input  logic signed [31:0] operand,
	input  logic signed [31:0] in_value,
	output logic               res_valid,
	input  logic               res_stall,
	output logic [9:0]         next_index,
	output logic               out_valid,
	output logic signed [31:0] out_value,
	output logic               halted,
	output logic [2:0]         fault
);
	// command and status between sequencer and datapath
	cmd_t  cmd;
	stat_t stat;

	smx_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	// stacks, registers and arithmetic
	smx_dp #(
		.VALUE_STACK_DEPTH  (VALUE_STACK_DEPTH),
		.RETURN_STACK_DEPTH (RETURN_STACK_DEPTH),
		.PROGRAM_LENGTH     (PROGRAM_LENGTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.op         (op),
		.operand    (operand),
		.in_value   (in_value),
		.next_index (next_index),
		.out_valid  (out_valid),
		.out_value  (out_value),
		.halted     (halted),
		.fault      (fault)
	);
endmodule

FILE: rtl/smx_div.sv
// restoring divider for unsigned magnitudes, one quotient bit per cycle
module smx_div import smx_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] num,
	input  logic [31:0] den,
	output logic        done,
	output logic [47:0] quo
);
	logic [5:0]  cnt_q;
	logic [47:0] quo_q;
	logic [31:0] rem_q;
	logic [31:0] den_q;
	logic [32:0] shifted;
	logic [33:0] diff;
	logic        ge;

	assign shifted = {rem_q, quo_q[47]};
	assign diff    = {1'b0, shifted} - {2'b00, den_q};
	assign ge      = !diff[33];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= 6'(DIV_STEPS);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 6'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= {num, 16'h0000};
			rem_q <= '0;
			den_q <= den;
		end else if (cnt_q != '0) begin
			rem_q <= ge ? diff[31:0] : shifted[31:0];
			quo_q <= {quo_q[46:0], ge};
		end
	end

	assign done = (cnt_q == '0);
	assign quo  = quo_q;
endmodule

FILE: rtl/smx_ctrl.sv
// sequencer for one instruction: accept, execute, optional divide, commit
`include "assert_macros.svh"
module smx_ctrl import smx_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_stall,
	output logic  res_valid,
	input  logic  res_stall,
	input  stat_t stat,
	output cmd_t  cmd
);
	state_t state_q, state_d;
	logic   res_valid_q;
	logic   out_free;

	assign out_free = !res_valid_q || !res_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d    = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (stat.div_go) begin
					cmd.start_div = 1'b1;
					state_d       = ST_DIV;
				end else begin
					state_d = ST_FIN;
				end
			end
			ST_DIV: begin
				if (stat.div_done) state_d = ST_FIN;
			end
			ST_FIN: begin
				if (out_free) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	assign res_valid = res_valid_q;

	`ASSERT_IMPLY(a_commit_free, cmd.commit, !res_valid_q || !res_stall, "commit over held result")
	`ASSERT_NEXT(a_div_enter, cmd.start_div, state_q == ST_DIV, "divide start lost")
	`ASSERT_IMPLY(a_res_rise, $rose(res_valid_q), $past(cmd.commit), "result without commit")
endmodule

FILE: rtl/smx_dp.sv
// datapath: stacks, registers, program index, alu and result register
module smx_dp import smx_pkg::*; #(
	parameter int VALUE_STACK_DEPTH  = VALUE_STACK_DEPTH_DEF,
	parameter int RETURN_STACK_DEPTH = RETURN_STACK_DEPTH_DEF,
	parameter int PROGRAM_LENGTH     = PROGRAM_LENGTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  cmd_t               cmd,
	output stat_t              stat,
	input  logic [4:0]         op,
	input  logic signed [31:0] operand,
	input  logic signed [31:0] in_value,
	output logic [9:0]         next_index,
	output logic               out_valid,
	output logic signed [31:0] out_value,
	output logic               halted,
	output logic [2:0]         fault
);
	localparam int VDW = $clog2(VALUE_STACK_DEPTH + 1);
	localparam int VAW = $clog2(VALUE_STACK_DEPTH);
	localparam int RDW = $clog2(RETURN_STACK_DEPTH + 1);
	localparam int RAW = (RETURN_STACK_DEPTH > 1) ? $clog2(RETURN_STACK_DEPTH) : 1;
	localparam int PCW = $clog2(PROGRAM_LENGTH);

	logic signed [31:0] vmem [VALUE_STACK_DEPTH];
	logic [PCW-1:0]     rmem [RETURN_STACK_DEPTH];
	logic signed [31:0] regs_q [4];

	logic [VDW-1:0] vd_q, vd_d, vtop, vsec;
	logic [RDW-1:0] rd_q, rd_d, rtop;
	logic [PCW-1:0] pc_q, pc_d, adv, tgt, ret_q;
	logic           halt_q, halt_d;

	logic [4:0]         op_q;
	logic signed [31:0] opnd_q, inv_q, a_q, b_q;
	logic signed [63:0] prod_q;

	logic               vwe, rwe, gwe, ov;
	logic [VAW-1:0]     vwa;
	logic signed [31:0] vwd, ovd;
	logic [2:0]         flt;

	logic        reg_ok, tgt_ok, take, lt2, empty, full;
	logic [1:0]  rk;
	logic [PCW:0] pc_inc;
	logic signed [32:0] sum, dif;
	logic signed [63:0] madj, msh;
	logic signed [31:0] alu;
	logic [31:0] mag_a, mag_b;
	logic [47:0] quo;
	logic        div_done;
	logic [31:0] pcx;

	assign vtop = vd_q - VDW'(1);
	assign vsec = vd_q - VDW'(2);
	assign rtop = rd_q - RDW'(1);

	// operand latch and stack reads at accept
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q   <= op;
			opnd_q <= operand;
			inv_q  <= in_value;
			a_q    <= vmem[vtop[VAW-1:0]];
			b_q    <= vmem[vsec[VAW-1:0]];
			ret_q  <= rmem[rtop[RAW-1:0]];
		end
		prod_q <= a_q * b_q;
	end

	always_ff @(posedge clk) begin
		if (vwe) vmem[vwa] <= vwd;
		if (rwe) rmem[rd_q[RAW-1:0]] <= adv;
	end

	assign mag_a = a_q[31] ? 32'(-a_q) : 32'(a_q);
	assign mag_b = b_q[31] ? 32'(-b_q) : 32'(b_q);

	smx_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.start_div),
		.num    (mag_a),
		.den    (mag_b),
		.done   (div_done),
		.quo    (quo)
	);

	assign reg_ok = (opnd_q[15:0] == 16'h0000) && (opnd_q[31:18] == 14'h0000);
	assign rk     = opnd_q[17:16];
	assign tgt_ok = (!opnd_q[31] && ({2'b00, opnd_q[30:16]} < 17'(PROGRAM_LENGTH))) ||
			(opnd_q[31] && (opnd_q[31:16] == 16'hFFFF) && (opnd_q[15:0] != 16'h0000));
	assign tgt    = opnd_q[31] ? '0 : opnd_q[16 +: PCW];
	assign pc_inc = {1'b0, pc_q} + (PCW+1)'(1);
	assign adv    = (pc_inc >= (PCW+1)'(PROGRAM_LENGTH)) ? '0 : pc_inc[PCW-1:0];
	assign lt2    = (vd_q < VDW'(2));
	assign empty  = (vd_q == '0);
	assign full   = (vd_q >= VDW'(VALUE_STACK_DEPTH));

	assign stat.div_go   = !halt_q && (op_q == OP_DIV) && !lt2 && (b_q != 32'sd0);
	assign stat.div_done = div_done;

	// arithmetic, saturating to 32 bits
	assign sum  = {a_q[31], a_q} + {b_q[31], b_q};
	assign dif  = {a_q[31], a_q} - {b_q[31], b_q};
	assign madj = prod_q + (prod_q[63] ? 64'sd65535 : 64'sd0);
	assign msh  = madj >>> 16;

	always_comb begin
		case (op_q)
			OP_ADD: begin
				if (sum[32] != sum[31]) alu = sum[32] ? 32'sh80000000 : 32'sh7FFFFFFF;
				else alu = sum[31:0];
			end
			OP_SUB: begin
				if (dif[32] != dif[31]) alu = dif[32] ? 32'sh80000000 : 32'sh7FFFFFFF;
				else alu = dif[31:0];
			end
			OP_MUL: begin
				if (msh > 64'sh7FFFFFFF) alu = 32'sh7FFFFFFF;
				else if (msh < -64'sh80000000) alu = 32'sh80000000;
				else alu = msh[31:0];
			end
			default: begin
				if (a_q[31] ^ b_q[31]) begin
					if (quo > 48'h80000000) alu = 32'sh80000000;
					else alu = 32'(-quo[31:0]);
				end else begin
					if (quo > 48'h7FFFFFFF) alu = 32'sh7FFFFFFF;
					else alu = quo[31:0];
				end
			end
		endcase
	end

	always_comb begin
		case (op_q)
			OP_JA:   take = a_q > b_q;
			OP_JAE:  take = a_q >= b_q;
			OP_JB:   take = a_q < b_q;
			OP_JBE:  take = a_q <= b_q;
			OP_JE:   take = a_q == b_q;
			default: take = a_q != b_q;
		endcase
	end

	// instruction effect
	always_comb begin
		vwe    = 1'b0;
		rwe    = 1'b0;
		gwe    = 1'b0;
		ov     = 1'b0;
		ovd    = '0;
		vwa    = vd_q[VAW-1:0];
		vwd    = a_q;
		flt    = FLT_NONE;
		vd_d   = vd_q;
		rd_d   = rd_q;
		pc_d   = adv;
		halt_d = halt_q;
		if (halt_q) begin
			pc_d = pc_q;
		end else begin
			case (op_q)
				OP_PUSH, OP_IN: begin
					if (full) flt = FLT_OVER;
					else begin
						vwe  = 1'b1;
						vwd  = (op_q == OP_PUSH) ? opnd_q : inv_q;
						vd_d = vd_q + VDW'(1);
					end
				end
				OP_PUSHREG: begin
					if (!reg_ok) flt = FLT_BADREG;
					else if (full) flt = FLT_OVER;
					else begin
						vwe  = 1'b1;
						vwd  = regs_q[rk];
						vd_d = vd_q + VDW'(1);
					end
				end
				OP_POPREG: begin
					if (!reg_ok) flt = FLT_BADREG;
					else if (empty) flt = FLT_UNDER;
					else begin
						gwe  = 1'b1;
						vd_d = vtop;
					end
				end
				OP_JA, OP_JAE, OP_JB, OP_JBE, OP_JE, OP_JNE: begin
					if (lt2) flt = FLT_UNDER;
					else if (take && !tgt_ok) flt = FLT_TARGET;
					else begin
						vd_d = vsec;
						if (take) pc_d = tgt;
					end
				end
				OP_JMP: begin
					if (!tgt_ok) flt = FLT_TARGET;
					else pc_d = tgt;
				end
				OP_CALL: begin
					if (!tgt_ok) flt = FLT_TARGET;
					else if (rd_q >= RDW'(RETURN_STACK_DEPTH)) flt = FLT_CALL;
					else begin
						rwe  = 1'b1;
						rd_d = rd_q + RDW'(1);
						pc_d = tgt;
					end
				end
				OP_RET: begin
					if (rd_q == '0) flt = FLT_CALL;
					else begin
						rd_d = rtop;
						pc_d = ret_q;
					end
				end
				OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
					if (lt2) flt = FLT_UNDER;
					else if ((op_q == OP_DIV) && (b_q == 32'sd0)) flt = FLT_DIVZ;
					else begin
						vwe  = 1'b1;
						vwa  = vsec[VAW-1:0];
						vwd  = alu;
						vd_d = vtop;
					end
				end
				OP_DUP: begin
					if (empty) flt = FLT_UNDER;
					else if (full) flt = FLT_OVER;
					else begin
						vwe  = 1'b1;
						vd_d = vd_q + VDW'(1);
					end
				end
				OP_OUT: begin
					if (empty) flt = FLT_UNDER;
					else begin
						ov   = 1'b1;
						ovd  = a_q;
						vd_d = vtop;
					end
				end
				OP_END: begin
					halt_d = 1'b1;
					pc_d   = pc_q;
				end
				default: ;
			endcase
			if (flt != FLT_NONE) pc_d = pc_q;
		end
		if (!cmd.commit) begin
			vwe = 1'b0;
			rwe = 1'b0;
			gwe = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vd_q   <= '0;
			rd_q   <= '0;
			pc_q   <= '0;
			halt_q <= 1'b0;
			for (int i = 0; i < 4; i++) regs_q[i] <= '0;
		end else if (cmd.commit) begin
			vd_q   <= vd_d;
			rd_q   <= rd_d;
			pc_q   <= pc_d;
			halt_q <= halt_d;
			if (gwe) regs_q[rk] <= a_q;
		end
	end

	assign pcx = 32'(pc_d);

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			next_index <= pcx[9:0];
			out_valid  <= ov;
			out_value  <= ovd;
			halted     <= halt_d;
			fault      <= flt;
		end
	end
endmodule
